>>> hdl/sgra_pkg.sv
`timescale 1ns / 1ps

package sgra_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_LEFT    = 0;
  localparam int CH_RIGHT   = 1;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;
  localparam int FRAMES_W   = 16;
  localparam int IN_DATA_W  = 2 * SAMPLE_W + 2 * GAIN_W;
  localparam int OUT_DATA_W = 2 * SAMPLE_W;

  // number of quotient bits of the interpolation divide worked out per cycle
  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES         = GAIN_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

  localparam logic [GAIN_W-1:0]   GAIN_ONE     = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [FRAMES_W-1:0] SMOOTH_RESET = FRAMES_W'(352);

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_SET   = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [GAIN_W-1:0]   gain_t;
  typedef logic        [FRAMES_W-1:0] frames_t;

  typedef struct packed {
    logic load;
    logic prod_en;
    logic div_en;
    logic gain_en;
    logic apply_en;
  } sgra_cmd_t;

  typedef struct packed {
    logic ramp_now;
    logic is_set;
    logic out_busy;
  } sgra_stat_t;

endpackage

>>> hdl/sgra_ctrl.sv
`timescale 1ns / 1ps

module sgra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  sgra_pkg::sgra_stat_t stat,
  output sgra_pkg::sgra_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_DIV,
    S_GAIN,
    S_APPLY
  } state_t;

  state_t                          state_r, state_nxt;
  logic [sgra_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.ramp_now ? S_PROD : S_GAIN;
        end
      end
      S_PROD: begin
        cmd.prod_en = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == sgra_pkg::DIV_CNT_W'(sgra_pkg::DIV_CYCLES - 1)) begin
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.gain_en = 1'b1;
        state_nxt   = S_APPLY;
      end
      S_APPLY: begin
        // a frame waits here while the previous result is still unclaimed
        if (stat.is_set || !stat.out_busy) begin
          cmd.apply_en = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> hdl/sgra_datapath.sv
`timescale 1ns / 1ps

module sgra_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [sgra_pkg::FRAMES_W-1:0]       cfg_data,
  input  logic                                in_cmd,
  input  logic [sgra_pkg::IN_DATA_W-1:0]      in_data,
  output logic [sgra_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                                out_active,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  sgra_pkg::sgra_cmd_t                 cmd,
  output sgra_pkg::sgra_stat_t                stat
);

  localparam int SW = sgra_pkg::SAMPLE_W;
  localparam int GW = sgra_pkg::GAIN_W;
  localparam int NC = sgra_pkg::CHANNELS;

  // ramp state
  sgra_pkg::frames_t smooth_r;
  sgra_pkg::gain_t   old_r [NC];
  sgra_pkg::gain_t   tgt_r [NC];
  sgra_pkg::frames_t pos_r;
  logic              unset_r;

  // item in flight
  logic              cmd_r;
  logic              ramp_r;
  sgra_pkg::sample_t smp_r  [NC];
  sgra_pkg::gain_t   new_r  [NC];
  sgra_pkg::gain_t   dmag_r [NC];
  logic              neg_r  [NC];
  logic [GW-1:0]     rem_r  [NC];
  logic [GW-1:0]     dvd_r  [NC];
  sgra_pkg::gain_t   gain_r [NC];

  // result register
  sgra_pkg::sample_t out_r [NC];
  logic              act_r;
  logic              out_valid_r;

  logic              ramp_now;
  logic [GW-1:0]     rem_nxt [NC];
  logic [GW-1:0]     dvd_nxt [NC];
  logic [GW:0]       trial   [NC];
  logic              qbit    [NC];
  sgra_pkg::sample_t scaled  [NC];

  function automatic sgra_pkg::sample_t scale(input sgra_pkg::sample_t s,
                                              input sgra_pkg::gain_t g);
    logic signed [SW+GW:0] prod;
    logic signed [SW+GW:0] sum;
    logic signed [SW+1:0]  r;
    prod = (SW+GW+1)'(s) * $signed({{(SW+1){1'b0}}, g});
    sum  = prod + $signed((SW+GW+1)'(1) << (sgra_pkg::GAIN_FRAC - 1));
    r    = $signed(sum[SW+GW:sgra_pkg::GAIN_FRAC]);
    if (r > $signed((SW+2)'((1 << (SW - 1)) - 1))) begin
      return sgra_pkg::sample_t'((1 << (SW - 1)) - 1);
    end else if (r < -$signed((SW+2)'(1 << (SW - 1)))) begin
      return sgra_pkg::sample_t'(1 << (SW - 1));
    end
    return r[SW-1:0];
  endfunction

  assign ramp_now = !unset_r && (pos_r < smooth_r);

  // restoring divide of |diff|*pos by the ramp length, DIV_BITS_PER_CYCLE quotient bits a cycle
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      rem_nxt[c] = rem_r[c];
      dvd_nxt[c] = dvd_r[c];
      trial[c]   = '0;
      qbit[c]    = 1'b0;
      for (int k = 0; k < sgra_pkg::DIV_BITS_PER_CYCLE; k++) begin
        trial[c] = {rem_nxt[c], dvd_nxt[c][GW-1]};
        if (trial[c] >= {1'b0, smooth_r}) begin
          rem_nxt[c] = GW'(trial[c] - {1'b0, smooth_r});
          qbit[c]    = 1'b1;
        end else begin
          rem_nxt[c] = trial[c][GW-1:0];
          qbit[c]    = 1'b0;
        end
        dvd_nxt[c] = {dvd_nxt[c][GW-2:0], qbit[c]};
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      scaled[c] = scale(smp_r[c], gain_r[c]);
    end
  end

  // configuration and ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= sgra_pkg::SMOOTH_RESET;
      for (int c = 0; c < NC; c++) begin
        old_r[c] <= sgra_pkg::GAIN_ONE;
        tgt_r[c] <= sgra_pkg::GAIN_ONE;
      end
      pos_r   <= '0;
      unset_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        smooth_r <= cfg_data;
      end
      if (cmd.apply_en) begin
        if (cmd_r == sgra_pkg::CMD_SET) begin
          for (int c = 0; c < NC; c++) begin
            old_r[c] <= gain_r[c];
            tgt_r[c] <= new_r[c];
          end
          pos_r   <= unset_r ? smooth_r : '0;
          unset_r <= 1'b0;
        end else if (ramp_r) begin
          pos_r <= pos_r + 1'b1;
        end else if (unset_r) begin
          unset_r <= 1'b0;
          pos_r   <= (smooth_r == '0) ? '0 : sgra_pkg::frames_t'(1);
        end
      end
    end
  end

  // item registers, product, divide and gain
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      ramp_r <= ramp_now;
      for (int c = 0; c < NC; c++) begin
        smp_r[c]  <= in_data[c*SW +: SW];
        new_r[c]  <= in_data[NC*SW + c*GW +: GW];
        neg_r[c]  <= tgt_r[c] < old_r[c];
        dmag_r[c] <= (tgt_r[c] < old_r[c]) ? old_r[c] - tgt_r[c] : tgt_r[c] - old_r[c];
      end
    end
    if (cmd.prod_en) begin
      for (int c = 0; c < NC; c++) begin
        {rem_r[c], dvd_r[c]} <= {{GW{1'b0}}, dmag_r[c]} * {{(2*GW-sgra_pkg::FRAMES_W){1'b0}}, pos_r};
      end
    end
    if (cmd.div_en) begin
      for (int c = 0; c < NC; c++) begin
        rem_r[c] <= rem_nxt[c];
        dvd_r[c] <= dvd_nxt[c];
      end
    end
    if (cmd.gain_en) begin
      for (int c = 0; c < NC; c++) begin
        if (!ramp_r) begin
          gain_r[c] <= tgt_r[c];
        end else if (neg_r[c]) begin
          gain_r[c] <= old_r[c] - dvd_r[c];
        end else begin
          gain_r[c] <= old_r[c] + dvd_r[c];
        end
      end
    end
    if (cmd.apply_en && cmd_r == sgra_pkg::CMD_FRAME) begin
      for (int c = 0; c < NC; c++) begin
        out_r[c] <= scaled[c];
      end
      act_r <= ramp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply_en && cmd_r == sgra_pkg::CMD_FRAME) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_data      = {out_r[sgra_pkg::CH_RIGHT], out_r[sgra_pkg::CH_LEFT]};
  assign out_active    = act_r;
  assign out_valid     = out_valid_r;
  assign stat.ramp_now = ramp_now;
  assign stat.is_set   = (cmd_r == sgra_pkg::CMD_SET);
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

>>> hdl/stereo_gain_ramp_applier_unit.sv
// stereo gain stage with a linear gain ramp. each input transfer is either a
// stereo frame (in_tuser low) or a set-gains command (in_tuser high). a frame
// gives one output transfer with both samples scaled by the current q1.15 gain,
// rounded half up and saturated to 16 bits; out_tuser is high while the gain is
// still being interpolated. a set-gains command gives no output: it freezes the
// gain in use as the start of a ramp to the new targets, which then runs over
// smooth_frames frames (cfg port, reset 352). after reset the gains are 1.0 and
// the ramp is unset until the first frame or command (a command then takes its
// targets at once). with no ramp in progress an item goes straight to the gain
// and apply steps; one that needs an interpolated gain first has one multiply of
// the gain difference by the ramp position, then a 16-bit divide by the ramp
// length that produces four quotient bits per cycle, both channels side by side.
// the output is a register, so a new item is accepted while a result waits; a
// frame only stalls at its final step if the previous result has still not been
// taken. write the configuration only while the block is idle
`timescale 1ns / 1ps

module stereo_gain_ramp_applier_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // ramp length in frames
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgra_pkg::FRAMES_W-1:0]     cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sgra_pkg::IN_DATA_W-1:0]    in_tdata,  // sample_left, sample_right, gain_left, gain_right
  input  logic                              in_tuser,  // cmd
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sgra_pkg::OUT_DATA_W-1:0]   out_tdata, // out_left, out_right
  output logic                              out_tuser  // ramp_active
);

  sgra_pkg::sgra_cmd_t  cmd;
  sgra_pkg::sgra_stat_t stat;

  // the register is always writable
  assign cfg_ready = 1'b1;

  sgra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sgra_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_cmd     (in_tuser),
    .in_data    (in_tdata),
    .out_data   (out_tdata),
    .out_active (out_tuser),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // at most one step of the sequence is commanded in any cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.prod_en, cmd.div_en, cmd.gain_en, cmd.apply_en}))
    else $error("more than one datapath command at once");

  // a transfer on the input leaves the block busy in the next cycle
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // a frame result is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply_en && !stat.is_set) |-> !stat.out_busy)
    else $error("result overwritten before transfer");

  // a set-gains command never produces a result
  a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply_en && stat.is_set && !out_tvalid) |=> !out_tvalid)
    else $error("set-gains command raised a result");

endmodule
